@@ src/hkot_pkg.sv @@
// Shared types and constants for the held key order tracker.
package hkot_pkg;

	localparam logic [7:0] CODE_LSHIFT = 8'hA0;
	localparam logic [7:0] CODE_RSHIFT = 8'hA1;
	localparam logic [7:0] CODE_SHIFT  = 8'h10;
	localparam logic [7:0] CODE_LCTRL  = 8'hA2;
	localparam logic [7:0] CODE_RCTRL  = 8'hA3;
	localparam logic [7:0] CODE_CTRL   = 8'h11;
	localparam logic [7:0] CODE_LALT   = 8'hA4;
	localparam logic [7:0] CODE_RALT   = 8'hA5;
	localparam logic [7:0] CODE_ALT    = 8'h12;

	typedef struct packed {
		logic [7:0] key_code;
		logic       is_press;
	} item_t;

	typedef struct packed {
		logic [7:0] event_code;
		logic       event_press;
		logic       code_now_held;
		logic [7:0] newest_code;
		logic [4:0] order_count;
		logic       shift_held;
		logic       ctrl_held;
		logic       alt_held;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic update;
		logic scan;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic press;
		logic empty;
		logic scan_last;
	} sts_t;

endpackage

@@ src/hkot_ctrl.sv @@
// Controller state machine: sequences load, update, list compaction and result hand-off.
module hkot_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	output logic            result_valid,
	input  logic            result_stall,
	input  hkot_pkg::sts_t  sts,
	output hkot_pkg::cmd_t  cmd
);
	import hkot_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !result_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!sts.press && !sts.empty) state_nxt = ST_SCAN;
				else state_nxt = ST_EMIT;
			end
			ST_SCAN: begin
				if (sts.scan_last) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall = (state_q != ST_IDLE);
		cmd        = '0;
		case (state_q)
			ST_IDLE:   cmd.load = item_valid;
			ST_UPDATE: cmd.update = 1'b1;
			ST_SCAN:   cmd.scan = 1'b1;
			ST_EMIT:   cmd.emit = slot_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!result_stall) out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;

endmodule

@@ src/hkot_dp.sv @@
// Datapath: held bitmap, press-order list, compaction counters and result register.
module hkot_dp #(
	parameter int ORDER_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hkot_pkg::item_t   item,
	input  hkot_pkg::cmd_t    cmd,
	output hkot_pkg::sts_t    sts,
	output hkot_pkg::result_t result
);
	import hkot_pkg::*;

	localparam int IW = (ORDER_DEPTH > 1) ? $clog2(ORDER_DEPTH) : 1;
	localparam int LW = $clog2(ORDER_DEPTH + 1);
	localparam logic [LW-1:0] DEPTH_L = LW'(ORDER_DEPTH);

	logic [7:0]    code_q;
	logic          press_q;
	logic [255:0]  held_q, held_nxt;
	logic [7:0]    list_q [ORDER_DEPTH];
	logic [LW-1:0] len_q;
	logic [IW-1:0] i_q;
	logic [LW-1:0] k_q, k_nxt;
	logic          keep;
	logic          add_new;
	result_t       result_q;

	// side keys drive the generic code; it drops only when both sides are up
	always_comb begin
		held_nxt         = held_q;
		held_nxt[code_q] = press_q;
		if (code_q == CODE_LSHIFT || code_q == CODE_RSHIFT) begin
			if (press_q) held_nxt[CODE_SHIFT] = 1'b1;
			else if (!held_nxt[CODE_LSHIFT] && !held_nxt[CODE_RSHIFT])
				held_nxt[CODE_SHIFT] = 1'b0;
		end
		if (code_q == CODE_LCTRL || code_q == CODE_RCTRL) begin
			if (press_q) held_nxt[CODE_CTRL] = 1'b1;
			else if (!held_nxt[CODE_LCTRL] && !held_nxt[CODE_RCTRL])
				held_nxt[CODE_CTRL] = 1'b0;
		end
		if (code_q == CODE_LALT || code_q == CODE_RALT) begin
			if (press_q) held_nxt[CODE_ALT] = 1'b1;
			else if (!held_nxt[CODE_LALT] && !held_nxt[CODE_RALT])
				held_nxt[CODE_ALT] = 1'b0;
		end
	end

	assign add_new = press_q && !held_q[code_q];
	assign keep    = (list_q[i_q] != code_q);
	assign k_nxt   = k_q + LW'(keep);

	assign sts.press     = press_q;
	assign sts.empty     = (len_q == '0);
	assign sts.scan_last = ((LW'(i_q) + LW'(1)) == len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			len_q  <= '0;
			i_q    <= '0;
			k_q    <= '0;
		end else begin
			if (cmd.update) begin
				held_q <= held_nxt;
				i_q    <= '0;
				k_q    <= '0;
				if (add_new && len_q < DEPTH_L) len_q <= len_q + LW'(1);
			end
			if (cmd.scan) begin
				i_q <= i_q + IW'(1);
				k_q <= k_nxt;
				if (sts.scan_last) len_q <= k_nxt;
			end
		end
	end

	// list entries: shift in on a new press, compact in place on a release
	always_ff @(posedge clk) begin
		if (cmd.update && add_new) begin
			for (int j = ORDER_DEPTH - 1; j > 0; j--) list_q[j] <= list_q[j-1];
			list_q[0] <= code_q;
		end
		if (cmd.scan && keep) list_q[k_q[IW-1:0]] <= list_q[i_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q  <= item.key_code;
			press_q <= item.is_press;
		end
		if (cmd.emit) begin
			result_q.event_code    <= code_q;
			result_q.event_press   <= press_q;
			result_q.code_now_held <= held_q[code_q];
			result_q.newest_code   <= (len_q == '0) ? 8'd0 : list_q[0];
			result_q.order_count   <= 5'(len_q);
			result_q.shift_held    <= held_q[CODE_SHIFT];
			result_q.ctrl_held     <= held_q[CODE_CTRL];
			result_q.alt_held      <= held_q[CODE_ALT];
		end
	end

	assign result = result_q;

endmodule

@@ src/held_key_order_tracker.sv @@
// Sequence: accept in IDLE, then UPDATE, then EMIT into the registered result;
// a release with a non-empty list runs SCAN before EMIT, one entry compacted per cycle.
// One item at a time; a stalled result can hold EMIT, yet the next item is taken while
// the previous result still waits in the output register.
// Reset: held map, list length and controller cleared; list entries are not.
module held_key_order_tracker #(
	parameter int ORDER_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  hkot_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output hkot_pkg::result_t result
);
	import hkot_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hkot_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	hkot_dp #(
		.ORDER_DEPTH (ORDER_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule
